### src/assert_macros.svh
// Assertion macros used by the datapath (ksds_dp.sv).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Whenever ante holds, cons must hold in the same cycle.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

### src/ksds_pkg.sv
// Shared constants, types and command codes of the k-smallest distinct set.
package ksds_pkg;

  localparam int CAPACITY = 10;
  localparam int VAL_W    = 20;
  localparam int CMD_W    = 2;
  localparam int LIM_W    = 4;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CMP_W    = (CNT_W > LIM_W) ? CNT_W : LIM_W;

  typedef logic [VAL_W-1:0] value_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [CMD_W-1:0] cmd_t;
  typedef logic [LIM_W-1:0] limit_t;

  localparam cmd_t CMD_CLEAR  = 2'd0;
  localparam cmd_t CMD_INSERT = 2'd1;
  localparam cmd_t CMD_EMIT   = 2'd2;

  // Controller -> datapath
  typedef struct packed {
    logic clear;
    logic insert;
    logic start_emit;
    logic emit_step;
    logic load_empty;
  } ctrl_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic slot_free;
    logic n_zero;
    logic last_step;
  } dp_stat_t;

endpackage

### src/ksds_in_if.sv
// Input channel: command items with valid/ready handshake.
interface ksds_in_if;
  import ksds_pkg::*;

  logic   valid;
  logic   ready;
  cmd_t   command;
  value_t value;
  limit_t limit;

  modport source (output valid, output command, output value, output limit, input ready);
  modport sink   (input valid, input command, input value, input limit, output ready);
endinterface

### src/ksds_out_if.sv
// Output channel: emitted values with valid/ready handshake.
interface ksds_out_if;
  import ksds_pkg::*;

  logic   valid;
  logic   ready;
  value_t item;
  logic   empty_res;
  logic   last;

  modport source (output valid, output item, output empty_res, output last, input ready);
  modport sink   (input valid, input item, input empty_res, input last, output ready);
endinterface

### src/ksds_ctrl.sv
// Controller FSM: sequences clear, insert and emit runs.
module ksds_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  ksds_pkg::cmd_t      in_command_i,
  input  ksds_pkg::dp_stat_t  stat_i,
  output logic                in_ready_o,
  output ksds_pkg::ctrl_cmd_t cmd_o
);
  import ksds_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic state_q, state_d;
  logic accept;

  assign accept = in_valid_i && in_ready_o;

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ST_IDLE: begin
        // hold off input until the output register can take a result
        in_ready_o = stat_i.slot_free;
        if (accept) begin
          case (in_command_i)
            CMD_CLEAR:  cmd_o.clear  = 1'b1;
            CMD_INSERT: cmd_o.insert = 1'b1;
            CMD_EMIT: begin
              if (stat_i.n_zero) begin
                cmd_o.load_empty = 1'b1;
              end else begin
                cmd_o.start_emit = 1'b1;
                state_d          = ST_EMIT;
              end
            end
            default: ;
          endcase
        end
      end
      ST_EMIT: begin
        if (stat_i.slot_free) begin
          cmd_o.emit_step = 1'b1;
          if (stat_i.last_step) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### src/ksds_dp.sv
// Datapath: sorted entry registers, parallel insert, emit counter, output register.
`include "assert_macros.svh"

module ksds_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ksds_pkg::ctrl_cmd_t cmd_i,
  input  ksds_pkg::value_t    value_i,
  input  ksds_pkg::limit_t    limit_i,
  input  logic                out_ready_i,
  output ksds_pkg::dp_stat_t  stat_o,
  output logic                out_valid_o,
  output ksds_pkg::value_t    item_o,
  output logic                empty_res_o,
  output logic                last_o
);
  import ksds_pkg::*;

  value_t entries_q [CAPACITY];
  value_t entries_d [CAPACITY];
  cnt_t   count_q, count_d;
  cnt_t   k_q, k_d;
  cnt_t   n_q, n_d;
  logic   ovalid_q, ovalid_d;
  value_t item_q, item_d;
  logic   empty_q, empty_d;
  logic   last_q, last_d;

  logic [CAPACITY-1:0] lt, eq;
  logic   full, ignore_ins;
  cnt_t   n_eff;
  logic   lim_below;

  // Parallel compare against every held entry
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      lt[i] = (CNT_W'(i) < count_q) && (entries_q[i] < value_i);
      eq[i] = (CNT_W'(i) < count_q) && (entries_q[i] == value_i);
    end
  end

  assign full       = (count_q == CNT_W'(CAPACITY));
  // duplicate, or full set with value not below the largest entry
  assign ignore_ins = (|eq) || (full && (&lt));

  assign lim_below = (CMP_W'(limit_i) < CMP_W'(count_q));
  assign n_eff     = lim_below ? CNT_W'(limit_i) : count_q;

  assign stat_o.slot_free = !ovalid_q || out_ready_i;
  assign stat_o.n_zero    = (n_eff == '0);
  assign stat_o.last_step = ((k_q + CNT_W'(1)) == n_q);

  always_comb begin
    entries_d = entries_q;
    count_d   = count_q;
    k_d       = k_q;
    n_d       = n_q;
    ovalid_d  = ovalid_q && !out_ready_i;
    item_d    = item_q;
    empty_d   = empty_q;
    last_d    = last_q;

    if (cmd_i.clear) begin
      count_d = '0;
    end

    if (cmd_i.insert && !ignore_ins) begin
      // entries below the slot stay, the slot takes the value, the rest shift up
      entries_d[0] = lt[0] ? entries_q[0] : value_i;
      for (int i = 1; i < CAPACITY; i++) begin
        if (lt[i]) begin
          entries_d[i] = entries_q[i];
        end else if (lt[i-1]) begin
          entries_d[i] = value_i;
        end else begin
          entries_d[i] = entries_q[i-1];
        end
      end
      if (!full) begin
        count_d = count_q + CNT_W'(1);
      end
    end

    if (cmd_i.start_emit) begin
      n_d = n_eff;
      k_d = '0;
    end

    if (cmd_i.emit_step) begin
      item_d   = entries_q[k_q[IDX_W-1:0]];
      empty_d  = 1'b0;
      last_d   = stat_o.last_step;
      ovalid_d = 1'b1;
      k_d      = k_q + CNT_W'(1);
    end

    if (cmd_i.load_empty) begin
      item_d   = '0;
      empty_d  = 1'b1;
      last_d   = 1'b1;
      ovalid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      k_q      <= '0;
      n_q      <= '0;
      ovalid_q <= 1'b0;
    end else begin
      count_q  <= count_d;
      k_q      <= k_d;
      n_q      <= n_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entries_q <= entries_d;
    item_q    <= item_d;
    empty_q   <= empty_d;
    last_q    <= last_d;
  end

  assign out_valid_o = ovalid_q;
  assign item_o      = item_q;
  assign empty_res_o = empty_q;
  assign last_o      = last_q;

  `ASSERT_ALWAYS(a_count_bound, clk_i, rst_ni, count_q <= CNT_W'(CAPACITY))
  `ASSERT_IMPLIES(a_step_in_range, clk_i, rst_ni, cmd_i.emit_step, k_q < n_q && n_q <= count_q)
  `ASSERT_IMPLIES(a_no_overwrite, clk_i, rst_ni, ovalid_q && !out_ready_i,
                  !cmd_i.emit_step && !cmd_i.load_empty)

endmodule

### src/k_smallest_distinct_set.sv
// Top level of the k-smallest distinct set: controller plus datapath.
//
// Usage:
//   in_i  carries commands: clear, insert value, emit up to limit values.
//   out_o carries results: item, empty_res, last. A transfer happens when
//         valid and ready are both high at a rising edge.
//   Clear and insert produce no result; the controller stays idle, so the next
//   command is taken as soon as an output slot is free.
//   Insert compares the value against all held entries in parallel and
//   writes the sorted, shifted row of entry registers when it is accepted.
//   Emit with n = min(limit, count) values: after the accept, values are
//   loaded into the output register one per cycle while a slot is free, and
//   the emit counter ends the run after n values; no command is taken meanwhile.
//   Emit with nothing to output loads one empty result in the accept cycle.
//   Unused command code 3 is taken and ignored.
//   Reset empties the set and drops any pending result; entry contents are
//   not cleared, only the fill count.
//   When the receiver stalls, the output register holds its result and
//   in_i.ready drops while a result waits and no slot is free; the emit
//   run pauses until the register is taken.
module k_smallest_distinct_set (
  input  logic              clk_i,
  input  logic              rst_ni,
  ksds_in_if.sink           in_i,
  ksds_out_if.source        out_o
);
  import ksds_pkg::*;

  ctrl_cmd_t ctrl_cmd;
  dp_stat_t  dp_stat;

  // Command sequencing: idle/emit states
  ksds_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_command_i (in_i.command),
    .stat_i       (dp_stat),
    .in_ready_o   (in_i.ready),
    .cmd_o        (ctrl_cmd)
  );

  // Entry storage, compare network, emit counter and output register
  ksds_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (ctrl_cmd),
    .value_i     (in_i.value),
    .limit_i     (in_i.limit),
    .out_ready_i (out_o.ready),
    .stat_o      (dp_stat),
    .out_valid_o (out_o.valid),
    .item_o      (out_o.item),
    .empty_res_o (out_o.empty_res),
    .last_o      (out_o.last)
  );

endmodule

### tb/sv/k_smallest_distinct_set_tb.sv
// Testbench for the k-smallest distinct set: directed and random command streams vs. a predictor.
`timescale 1ns / 1ps

module k_smallest_distinct_set_tb;
  import ksds_pkg::*;

  // Code 3 has no meaning; the block must take it and do nothing.
  localparam cmd_t   CMD_UNUSED   = 2'd3;
  localparam value_t VALUE_MAX    = '1;
  localparam limit_t LIMIT_MAX    = '1;
  localparam limit_t LIMIT_FULL   = limit_t'(CAPACITY);
  localparam int     GAP_MAX      = 6;     // longest idle burst on either side
  localparam int     LONG_HOLD    = 80;    // receiver hold-off during the pressure test
  localparam int     STALL_LIMIT  = 1000;  // cycles without any transfer before giving up
  localparam int     DRAIN_CYCLES = 24;    // quiet time after the last result
  localparam int     MAX_REPORTS  = 10;

  // One emitted result as seen on the output channel.
  typedef struct packed {
    value_t item;
    logic   empty_res;
    logic   last;
  } emit_beat_t;

  logic clk_i;
  logic rst_ni;

  ksds_in_if  in_ch ();
  ksds_out_if out_ch ();

  k_smallest_distinct_set uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // Predicted contents of the set: ascending, only [0, held_cnt) meaningful.
  value_t      held_vals [CAPACITY];
  int unsigned held_cnt;
  // Results the block still owes, oldest first.
  emit_beat_t  emit_queue [$];
  int unsigned fail_count;

  bit idle_on;      // random idle bursts on both channels
  bit hold_req;     // pressure test asks the receiver for a long hold-off
  bit hold_active;  // receiver has started that hold-off

  always #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Sorted insert with distinct values; a full set only admits a value below
  // its largest entry, which then drops off the top.
  function automatic void set_insert(value_t v);
    int unsigned pos;
    int unsigned top;
    pos = 0;
    for (int i = 0; i < held_cnt; i++) begin
      if (held_vals[i] == v) return;
      if (held_vals[i] < v) pos++;
    end
    if (held_cnt < CAPACITY) begin
      top = held_cnt;
      held_cnt++;
    end else begin
      if (pos >= CAPACITY) return;
      top = CAPACITY - 1;
    end
    for (int i = top; i > pos; i--) held_vals[i] = held_vals[i-1];
    held_vals[pos] = v;
  endfunction

  // Applies one accepted command and queues whatever results it owes.
  function automatic void predict_command(cmd_t cmd, value_t v, limit_t lim);
    int unsigned n;
    emit_beat_t  beat;
    case (cmd)
      CMD_CLEAR: begin
        held_cnt = 0;
      end
      CMD_INSERT: begin
        set_insert(v);
      end
      CMD_EMIT: begin
        n = (lim < held_cnt) ? lim : held_cnt;
        if (n == 0) begin
          // Nothing to stream: a single marker result.
          beat.item      = '0;
          beat.empty_res = 1'b1;
          beat.last      = 1'b1;
          emit_queue     = {emit_queue, beat};
        end else begin
          for (int k = 0; k < n; k++) begin
            beat.item      = held_vals[k];
            beat.empty_res = 1'b0;
            beat.last      = (k == n - 1);
            emit_queue     = {emit_queue, beat};
          end
        end
      end
      default: ;
    endcase
  endfunction

  // Compares one transferred result with the oldest one owed.
  function automatic void check_beat(value_t item, logic empty_res, logic last);
    emit_beat_t want;
    if (emit_queue.size() == 0) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("unexpected result: item=%h empty_res=%b last=%b", item, empty_res, last);
      return;
    end
    want = emit_queue.pop_front();
    if (item !== want.item || empty_res !== want.empty_res || last !== want.last) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("mismatch: expected item=%h empty_res=%b last=%b, got item=%h empty_res=%b last=%b",
                 want.item, want.empty_res, want.last, item, empty_res, last);
    end
  endfunction

  // Both channels are sampled at the same edge, before any NBA update lands.
  // Prediction goes first so a result can never outrun its command.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready)
        predict_command(in_ch.command, in_ch.value, in_ch.limit);
      if (out_ch.valid && out_ch.ready)
        check_beat(out_ch.item, out_ch.empty_res, out_ch.last);
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stall bursts, or one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        // Long hold-off: the output register fills and the block must stall
        // its input while the sender keeps offering commands.
        out_ch.ready <= 1'b0;
        hold_active = 1'b1;
        for (int c = 0; c < LONG_HOLD; c++) @(posedge clk_i);
        hold_req    = 1'b0;
        hold_active = 1'b0;
        out_ch.ready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, GAP_MAX)) @(posedge clk_i);
        out_ch.ready <= 1'b1;
      end else begin
        // Stretch of full throughput before the next chance to stall.
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(0, 12)) @(posedge clk_i);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: any transfer on either side counts as progress
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------

  // Offers one command and returns at the edge of its transfer. Valid stays
  // high afterwards so back-to-back commands need no idle gap between them.
  task automatic send_command(cmd_t cmd, value_t v, limit_t lim);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, GAP_MAX)) @(posedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.command <= cmd;
    in_ch.value   <= v;
    in_ch.limit   <= lim;
    do @(posedge clk_i); while (!(in_ch.valid === 1'b1 && in_ch.ready === 1'b1));
  endtask

  // Values cluster at both ends so duplicates and full-set rejects are common.
  function automatic value_t pick_value();
    case ($urandom_range(0, 3))
      0:       return value_t'($urandom_range(0, 31));
      1:       return VALUE_MAX - value_t'($urandom_range(0, 31));
      default: return value_t'($urandom);
    endcase
  endfunction

  // Mostly inserts and emits, with occasional clears so the set keeps
  // refilling; unused codes are mixed in but not counted.
  task automatic run_random_mix(int n_items);
    int sent;
    int pick;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        send_command(CMD_UNUSED, value_t'($urandom), limit_t'($urandom));
      end else begin
        if (pick < 8)
          send_command(CMD_CLEAR, value_t'($urandom), limit_t'($urandom));
        else if (pick < 70)
          send_command(CMD_INSERT, pick_value(), limit_t'($urandom));
        else
          send_command(CMD_EMIT, value_t'($urandom), limit_t'($urandom));
        sent++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Empty-set emits, field extremes, duplicates, oversize limit, unused code.
  task automatic test_empty_and_extremes();
    send_command(CMD_EMIT,   '0,        4'd5);        // empty set -> marker
    send_command(CMD_EMIT,   VALUE_MAX, '0);          // zero limit on empty set
    send_command(CMD_INSERT, '0,        LIMIT_MAX);
    send_command(CMD_INSERT, VALUE_MAX, '0);
    send_command(CMD_INSERT, '0,        '0);          // duplicate, ignored
    send_command(CMD_EMIT,   '0,        LIMIT_MAX);   // limit above held count
    send_command(CMD_EMIT,   '0,        '0);          // zero limit, non-empty set
    send_command(CMD_EMIT,   '0,        4'd1);        // single value, last set
    send_command(CMD_UNUSED, 20'h5a5a5, 4'ha);        // no effect at all
    send_command(CMD_EMIT,   '0,        LIMIT_FULL);
    send_command(CMD_CLEAR,  VALUE_MAX, LIMIT_MAX);
    send_command(CMD_EMIT,   '0,        LIMIT_FULL);  // cleared -> marker
  endtask

  // Fills the set front-first, then probes the full-set rules.
  task automatic test_full_set();
    for (int i = 0; i < CAPACITY; i++)
      send_command(CMD_INSERT, value_t'(1000 - 100 * i), '0);
    send_command(CMD_INSERT, value_t'(5000), '0);  // above largest, dropped
    send_command(CMD_INSERT, value_t'(1000), '0);  // equals largest, duplicate
    send_command(CMD_INSERT, value_t'(450),  '0);  // middle, largest evicted
    send_command(CMD_INSERT, value_t'(50),   '0);  // new minimum
    send_command(CMD_EMIT,   '0, LIMIT_FULL);
    send_command(CMD_EMIT,   '0, 4'd3);
  endtask

  task automatic test_random();
    run_random_mix(70);
  endtask

  // Receiver holds off while full-length emits pile up behind the output.
  task automatic test_backpressure();
    send_command(CMD_CLEAR, '0, '0);
    for (int i = 0; i < CAPACITY; i++)
      send_command(CMD_INSERT, pick_value(), '0);
    // nothing on offer while the receiver gets into its hold-off
    in_ch.valid <= 1'b0;
    hold_req = 1'b1;
    wait (hold_active);
    for (int i = 0; i < 6; i++) begin
      send_command(CMD_EMIT, '0, LIMIT_FULL);
      send_command(CMD_INSERT, pick_value(), '0);
    end
  endtask

  // Closing stretch at full rate on both sides.
  task automatic test_streaming();
    idle_on = 1'b0;
    run_random_mix(40);
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.command = CMD_CLEAR;
    in_ch.value   = '0;
    in_ch.limit   = '0;
    held_cnt      = 0;
    fail_count    = 0;
    idle_on       = 1'b1;
    hold_req      = 1'b0;
    hold_active   = 1'b0;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_empty_and_extremes();
    test_full_set();
    test_random();
    test_backpressure();
    test_streaming();
    in_ch.valid <= 1'b0;
    // let the predictor take the last transfer before looking at the queue
    @(posedge clk_i);

    // Wait for every owed result, then a quiet spell for anything extra.
    while (emit_queue.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_count == 0 && emit_queue.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

### sim.f
+incdir+src
src/ksds_pkg.sv
src/ksds_in_if.sv
src/ksds_out_if.sv
src/ksds_ctrl.sv
src/ksds_dp.sv
src/k_smallest_distinct_set.sv
tb/sv/k_smallest_distinct_set_tb.sv
